// ===== rtl/pidfd_pkg.sv =====
package pidfd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;
    localparam int ILIM_W    = 23;
    localparam int OLIM_W    = 15;
    localparam int K_W       = 16;
    localparam int DRIVE_W   = 16;

    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int DER_W     = DIFF_W;
    localparam int SUM_W     = ILIM_W + 1;
    localparam int SUMRAW_W  = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;

    // shared multiplier operands: a carries gains and filter weights, b the signals
    localparam int OPA_W     = K_W + 2;
    localparam int OPB_W     = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int Y_W       = ACC_W - GAIN_FRAC;

    localparam int K_ONE     = 1 << K_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ILIM_W;
    localparam int TDATA_IN_W = 2 * SAMPLE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN       = 3'd0,
        REG_INTEG_GAIN      = 3'd1,
        REG_DERIV_GAIN      = 3'd2,
        REG_INTEG_LIMIT     = 3'd3,
        REG_OUTPUT_LIMIT    = 3'd4,
        REG_DERIV_SMOOTHING = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_CLEAR   = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_FILT,
        ST_FACC,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [ILIM_W-1:0]        integ_limit;
        logic [OLIM_W-1:0]        output_limit;
        logic [K_W-1:0]           deriv_smoothing;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:       GAIN_W'(256),
        integ_gain:      '0,
        deriv_gain:      '0,
        integ_limit:     '1,
        output_limit:    '1,
        deriv_smoothing: '0
    };

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } mac_ctl_t;

endpackage

// ===== rtl/pid_controller_filtered_derivative_core.sv =====
// PID controller step engine with clamped integrator and low-pass filtered derivative.
// A compute beat (s_tuser = 0) takes setpoint and measurement and returns one saturated
// drive beat; a clear beat (s_tuser = 1) zeroes the integrator, the previous error and the
// filtered derivative and returns drive 0. The block takes one item at a time: s_tready
// is high only between items. A compute item steps through the states DIFF, FILT, FACC,
// PROP, INTEG, DERIV and OUT before the output register is loaded, a clear item goes
// straight to OUT, and the next item can be taken once the engine is back in IDLE; OUT
// waits while m_tready holds a finished beat back. The pace is set by one
// shared multiply-accumulate unit that makes five multiplies per step (two for the
// derivative filter, three for the gains) under a small sequencer. The output register
// holds a finished result while the next item is taken. Gains are signed Q8.8, the filter
// weight on the previous derivative is unsigned Q0.16, and all shifts round toward minus
// infinity. The user must write cfg registers only while idle; the block does not check.
module pid_controller_filtered_derivative_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pidfd_pkg::TDATA_IN_W-1:0]       s_tdata,   // setpoint, measured
    input  logic                                   s_tuser,   // opcode
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pidfd_pkg::DRIVE_W-1:0]          m_tdata,   // drive
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pidfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    pidfd_pkg::cfg_t     cfg;
    pidfd_pkg::mac_ctl_t mac_ctl;
    pidfd_pkg::state_t   state_reg, state_next;

    logic signed [pidfd_pkg::OPA_W-1:0]   mac_a;
    logic signed [pidfd_pkg::OPB_W-1:0]   mac_b;
    logic signed [pidfd_pkg::ACC_W-1:0]   acc;

    logic                                 out_valid_reg, out_valid_next;
    logic                                 clr_reg, clr_next;
    logic signed [pidfd_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic signed [pidfd_pkg::ERR_W-1:0]   perr_reg, perr_next;
    logic signed [pidfd_pkg::DER_W-1:0]   pder_reg, pder_next;
    logic signed [pidfd_pkg::ERR_W-1:0]   err_reg, err_next;
    logic signed [pidfd_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic [pidfd_pkg::DRIVE_W-1:0]        out_reg, out_next;

    logic signed [pidfd_pkg::SAMPLE_W-1:0]  setpoint;
    logic signed [pidfd_pkg::SAMPLE_W-1:0]  measured;
    logic signed [pidfd_pkg::SUMRAW_W-1:0]  sum_raw;
    logic signed [pidfd_pkg::SUMRAW_W-1:0]  ilim;
    logic signed [pidfd_pkg::Y_W-1:0]       y_raw;
    logic signed [pidfd_pkg::Y_W-1:0]       olim;
    logic signed [pidfd_pkg::Y_W-1:0]       y_sat;
    logic signed [pidfd_pkg::OPA_W-1:0]     k_ext;
    logic                                   s_accept;

    assign setpoint = s_tdata[pidfd_pkg::SAMPLE_W-1:0];
    assign measured = s_tdata[2*pidfd_pkg::SAMPLE_W-1:pidfd_pkg::SAMPLE_W];
    assign s_tready = (state_reg == pidfd_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    pidfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidfd_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    // integrator update and output saturation
    always_comb
    begin
        sum_raw = {{(pidfd_pkg::SUMRAW_W - pidfd_pkg::SUM_W){sum_reg[pidfd_pkg::SUM_W-1]}},
                   sum_reg}
                + {{(pidfd_pkg::SUMRAW_W - pidfd_pkg::ERR_W){err_reg[pidfd_pkg::ERR_W-1]}},
                   err_reg};
        ilim    = {{(pidfd_pkg::SUMRAW_W - pidfd_pkg::ILIM_W){1'b0}}, cfg.integ_limit};

        y_raw   = acc[pidfd_pkg::ACC_W-1:pidfd_pkg::GAIN_FRAC];
        olim    = {{(pidfd_pkg::Y_W - pidfd_pkg::OLIM_W){1'b0}}, cfg.output_limit};
        priority if (y_raw > olim)
        begin
            y_sat = olim;
        end
        else if (y_raw < -olim)
        begin
            y_sat = -olim;
        end
        else
        begin
            y_sat = y_raw;
        end

        k_ext = {{(pidfd_pkg::OPA_W - pidfd_pkg::K_W){1'b0}}, cfg.deriv_smoothing};
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        clr_next       = clr_reg;
        sum_next       = sum_reg;
        perr_next      = perr_reg;
        pder_next      = pder_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        out_next       = out_reg;
        mac_ctl        = '0;
        mac_a          = '0;
        mac_b          = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pidfd_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (pidfd_pkg::opcode_t'(s_tuser) == pidfd_pkg::OP_CLEAR)
                    begin
                        sum_next   = '0;
                        perr_next  = '0;
                        pder_next  = '0;
                        clr_next   = 1'b1;
                        state_next = pidfd_pkg::ST_OUT;
                    end
                    else
                    begin
                        err_next   = {setpoint[pidfd_pkg::SAMPLE_W-1], setpoint}
                                   - {measured[pidfd_pkg::SAMPLE_W-1], measured};
                        clr_next   = 1'b0;
                        state_next = pidfd_pkg::ST_DIFF;
                    end
                end
            end
            pidfd_pkg::ST_DIFF:
            begin
                diff_next = {err_reg[pidfd_pkg::ERR_W-1], err_reg}
                          - {perr_reg[pidfd_pkg::ERR_W-1], perr_reg};
                perr_next = err_reg;
                priority if (sum_raw > ilim)
                begin
                    sum_next = pidfd_pkg::SUM_W'(ilim);
                end
                else if (sum_raw < -ilim)
                begin
                    sum_next = pidfd_pkg::SUM_W'(-ilim);
                end
                else
                begin
                    sum_next = pidfd_pkg::SUM_W'(sum_raw);
                end
                // k * previous filtered derivative
                mac_ctl.mul_en = 1'b1;
                mac_a          = k_ext;
                mac_b          = {{(pidfd_pkg::OPB_W - pidfd_pkg::DER_W)
                                   {pder_reg[pidfd_pkg::DER_W-1]}}, pder_reg};
                state_next     = pidfd_pkg::ST_FILT;
            end
            pidfd_pkg::ST_FILT:
            begin
                // (1 - k) * raw derivative
                mac_ctl.mul_en  = 1'b1;
                mac_ctl.acc_en  = 1'b1;
                mac_ctl.acc_clr = 1'b1;
                mac_a           = pidfd_pkg::OPA_W'(pidfd_pkg::K_ONE) - k_ext;
                mac_b           = {{(pidfd_pkg::OPB_W - pidfd_pkg::DIFF_W)
                                    {diff_reg[pidfd_pkg::DIFF_W-1]}}, diff_reg};
                state_next      = pidfd_pkg::ST_FACC;
            end
            pidfd_pkg::ST_FACC:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.acc_en = 1'b1;
                mac_a          = {{(pidfd_pkg::OPA_W - pidfd_pkg::GAIN_W)
                                   {cfg.prop_gain[pidfd_pkg::GAIN_W-1]}}, cfg.prop_gain};
                mac_b          = {{(pidfd_pkg::OPB_W - pidfd_pkg::ERR_W)
                                   {err_reg[pidfd_pkg::ERR_W-1]}}, err_reg};
                state_next     = pidfd_pkg::ST_PROP;
            end
            pidfd_pkg::ST_PROP:
            begin
                // filter sum is complete, floor shift by the Q0.16 fraction
                pder_next       = acc[pidfd_pkg::K_W +: pidfd_pkg::DER_W];
                mac_ctl.mul_en  = 1'b1;
                mac_ctl.acc_en  = 1'b1;
                mac_ctl.acc_clr = 1'b1;
                mac_a           = {{(pidfd_pkg::OPA_W - pidfd_pkg::GAIN_W)
                                    {cfg.integ_gain[pidfd_pkg::GAIN_W-1]}}, cfg.integ_gain};
                mac_b           = {{(pidfd_pkg::OPB_W - pidfd_pkg::SUM_W)
                                    {sum_reg[pidfd_pkg::SUM_W-1]}}, sum_reg};
                state_next      = pidfd_pkg::ST_INTEG;
            end
            pidfd_pkg::ST_INTEG:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.acc_en = 1'b1;
                mac_a          = {{(pidfd_pkg::OPA_W - pidfd_pkg::GAIN_W)
                                   {cfg.deriv_gain[pidfd_pkg::GAIN_W-1]}}, cfg.deriv_gain};
                mac_b          = {{(pidfd_pkg::OPB_W - pidfd_pkg::DER_W)
                                   {pder_reg[pidfd_pkg::DER_W-1]}}, pder_reg};
                state_next     = pidfd_pkg::ST_DERIV;
            end
            pidfd_pkg::ST_DERIV:
            begin
                mac_ctl.acc_en = 1'b1;
                state_next     = pidfd_pkg::ST_OUT;
            end
            pidfd_pkg::ST_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = clr_reg ? '0 : pidfd_pkg::DRIVE_W'(y_sat);
                    out_valid_next = 1'b1;
                    state_next     = pidfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidfd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            clr_reg       <= 1'b0;
            sum_reg       <= '0;
            perr_reg      <= '0;
            pder_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
            sum_reg       <= sum_next;
            perr_reg      <= perr_next;
            pder_reg      <= pder_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        diff_reg <= diff_next;
        out_reg  <= out_next;
    end

endmodule

// ===== rtl/pidfd_cfg.sv =====
module pidfd_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pidfd_pkg::cfg_t                   cfg
);

    pidfd_pkg::cfg_t cfg_reg;
    pidfd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            // unknown indexes are dropped
            unique case (pidfd_pkg::cfg_reg_t'(cfg_index))
                pidfd_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain = cfg_data[pidfd_pkg::GAIN_W-1:0];
                pidfd_pkg::REG_INTEG_GAIN:
                    cfg_next.integ_gain = cfg_data[pidfd_pkg::GAIN_W-1:0];
                pidfd_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain = cfg_data[pidfd_pkg::GAIN_W-1:0];
                pidfd_pkg::REG_INTEG_LIMIT:
                    cfg_next.integ_limit = cfg_data[pidfd_pkg::ILIM_W-1:0];
                pidfd_pkg::REG_OUTPUT_LIMIT:
                    cfg_next.output_limit = cfg_data[pidfd_pkg::OLIM_W-1:0];
                pidfd_pkg::REG_DERIV_SMOOTHING:
                    cfg_next.deriv_smoothing = cfg_data[pidfd_pkg::K_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pidfd_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/pidfd_mac.sv =====
module pidfd_mac (
    input  logic                                  clk,
    input  pidfd_pkg::mac_ctl_t                   ctl,
    input  logic signed [pidfd_pkg::OPA_W-1:0]    op_a,
    input  logic signed [pidfd_pkg::OPB_W-1:0]    op_b,
    output logic signed [pidfd_pkg::ACC_W-1:0]    acc
);

    logic signed [pidfd_pkg::PROD_W-1:0] prod_reg;
    logic signed [pidfd_pkg::PROD_W-1:0] prod_next;
    logic signed [pidfd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [pidfd_pkg::ACC_W-1:0]  acc_next;
    logic signed [pidfd_pkg::ACC_W-1:0]  acc_base;
    logic signed [pidfd_pkg::ACC_W-1:0]  prod_ext;

    assign acc = acc_reg;

    always_comb
    begin
        prod_next = op_a * op_b;
        prod_ext  = {{(pidfd_pkg::ACC_W - pidfd_pkg::PROD_W){prod_reg[pidfd_pkg::PROD_W-1]}},
                     prod_reg};
        acc_base  = ctl.acc_clr ? '0 : acc_reg;
        acc_next  = acc_base + prod_ext;
    end

    // product is registered, and the accumulate adds it in the next cycle
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== rtl/pidfd_checker.sv =====
module pidfd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [pidfd_pkg::TDATA_IN_W-1:0]    s_tdata,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [pidfd_pkg::DRIVE_W-1:0]       m_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [pidfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [pidfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // a result beat held back keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled drive beat changed");

    // one item at a time: input closes right after a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after accept");

    // a clear beat with a free output answers zero once OUT loads the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && !m_tvalid
        |-> ##2 (m_tvalid && m_tdata == '0))
        else $error("clear did not answer zero");

    // the symmetric limit never lets the most negative code out
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != {1'b1, {(pidfd_pkg::DRIVE_W-1){1'b0}}})
        else $error("drive outside symmetric range");

endmodule

bind pid_controller_filtered_derivative_core pidfd_checker u_pidfd_checker (.*);
